FILE: rtl/core/rstb_pkg.sv
// rstb_pkg: shared types and constants for the rotation tracker with spin brake
// no dependencies
`default_nettype none

package rstb_pkg;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned VEL_W   = 24;
	localparam int unsigned SPEED_W = 23;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned CMD_W   = 9;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 72;

	localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;
	localparam logic [POS_W-1:0]   QUARTER_TURN = 32'h0000_4000;
	localparam logic [POS_W-1:0]   FULL_TURN    = 32'h0001_0000;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

	// register indexes
	localparam logic [1:0] REG_USE_MEASURED = 2'd0;
	localparam logic [1:0] REG_STEP_TIME    = 2'd1;
	localparam logic [1:0] REG_STALL_SPEED  = 2'd2;
	localparam logic [1:0] REG_BRAKE_DUTY   = 2'd3;

	typedef struct packed {
		logic                use_measured_angle;
		logic [STEP_W-1:0]   step_time;
		logic [SPEED_W-1:0]  stall_speed;
		logic [DUTY_W-1:0]   brake_duty;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]        measured_angle;
		logic signed [VEL_W-1:0]   velocity;
		logic                      activate;
		logic                      deactivate;
		logic [POS_W-1:0]          int_step;
	} in_beat_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]        angle_out;
		logic signed [POS_W-1:0]   unwrapped_angle;
		logic [COUNT_W-1:0]        rotations;
		logic                      brake_active;
		logic signed [CMD_W-1:0]   brake_command;
		logic                      brake_done;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rstb_cfg_regs.sv
// rstb_cfg_regs: apb register file for mode, step time, stall speed and brake duty
// depends on rstb_pkg
`default_nettype none

module rstb_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output rstb_pkg::cfg_t           cfg,
	output logic                     mode_wr
);
	import rstb_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en   = psel && penable && pwrite;
	assign mode_wr = wr_en && (paddr[3:2] == REG_USE_MEASURED);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_measured_angle <= 1'b1;
			cfg_q.step_time          <= 16'd655;
			cfg_q.stall_speed        <= 23'd10430;
			cfg_q.brake_duty         <= 8'd77;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_USE_MEASURED: cfg_q.use_measured_angle <= pwdata[0];
				REG_STEP_TIME:    cfg_q.step_time          <= pwdata[STEP_W-1:0];
				REG_STALL_SPEED:  cfg_q.stall_speed        <= pwdata[SPEED_W-1:0];
				REG_BRAKE_DUTY:   cfg_q.brake_duty         <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_USE_MEASURED: prdata = {31'd0, cfg_q.use_measured_angle};
			REG_STEP_TIME:    prdata = {16'd0, cfg_q.step_time};
			REG_STALL_SPEED:  prdata = {9'd0, cfg_q.stall_speed};
			REG_BRAKE_DUTY:   prdata = {24'd0, cfg_q.brake_duty};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/rstb_in_stage.sv
// rstb_in_stage: input register, also holds the floored velocity times step product
// depends on rstb_pkg
`default_nettype none

module rstb_in_stage (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic                              advance,
	input  wire logic [rstb_pkg::IN_TDATA_W-1:0]   tdata,
	input  wire logic [rstb_pkg::STEP_W-1:0]       step_time,
	output logic                                   valid_s1,
	output rstb_pkg::in_beat_t                     beat_s1
);
	import rstb_pkg::*;

	logic signed [VEL_W-1:0]   vel;
	logic signed [STEP_W:0]    step_s;
	logic signed [VEL_W+STEP_W:0] prod;

	assign vel    = $signed(tdata[39:16]);
	assign step_s = $signed({1'b0, step_time});
	assign prod   = vel * step_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// arithmetic shift floors the product
	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1.measured_angle <= tdata[15:0];
			beat_s1.velocity       <= vel;
			beat_s1.activate       <= tdata[40];
			beat_s1.deactivate     <= tdata[41];
			beat_s1.int_step       <= {{7{prod[VEL_W+STEP_W]}}, prod[VEL_W+STEP_W:STEP_W]};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rstb_track_core.sv
// rstb_track_core: angle unwrap or integration, turn counting and spin brake state
// depends on rstb_pkg
`default_nettype none

module rstb_track_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic                mode_wr,
	input  wire rstb_pkg::cfg_t      cfg,
	input  wire rstb_pkg::in_beat_t  beat_s1,
	output rstb_pkg::result_t        result
);
	import rstb_pkg::*;

	logic [ANGLE_W-1:0]  last_meas_q;
	logic                seen_q;
	logic [POS_W-1:0]    tracked_q;
	logic [POS_W-1:0]    rot_origin_q;
	logic [COUNT_W-1:0]  count_q;
	logic                braking_q;
	logic [POS_W-1:0]    brake_origin_q;
	logic [VEL_W-1:0]    target_q;

	logic [VEL_W-1:0]    speed;
	logic [ANGLE_W-1:0]  d;
	logic [POS_W-1:0]    meas_delta;
	logic [POS_W-1:0]    tracked_n;
	logic [POS_W-1:0]    disp;
	logic                full;
	logic [POS_W-1:0]    rot_origin_n;
	logic [COUNT_W-1:0]  count_n;
	logic                braking_n;
	logic [POS_W-1:0]    brake_origin_n;
	logic [VEL_W-1:0]    target_n;
	logic                braking_a;
	logic [POS_W-1:0]    brake_origin_a;
	logic [VEL_W-1:0]    target_a;
	logic [COUNT_W-1:0]  count_a;
	logic [POS_W-1:0]    bdiff;
	logic [POS_W-1:0]    travel;
	logic                done;
	logic signed [CMD_W-1:0] cmd;

	always_comb begin
		speed = beat_s1.velocity[VEL_W-1] ? VEL_W'(-beat_s1.velocity) : beat_s1.velocity;

		// exactly half a turn counts forward
		d = beat_s1.measured_angle - last_meas_q;
		meas_delta = {{(POS_W-ANGLE_W){d[ANGLE_W-1] && (d != HALF_TURN)}}, d};

		if (cfg.use_measured_angle) begin
			if (!seen_q) begin
				tracked_n = {{(POS_W-ANGLE_W){1'b0}}, beat_s1.measured_angle};
			end else begin
				tracked_n = tracked_q + meas_delta;
			end
		end else begin
			tracked_n = tracked_q + beat_s1.int_step;
		end

		disp = tracked_n - rot_origin_q;
		full = (!disp[POS_W-1] && (disp >= FULL_TURN)) ||
			(disp[POS_W-1] && ((-disp) >= FULL_TURN));

		count_n      = count_q;
		rot_origin_n = rot_origin_q;
		if (full) begin
			if (count_q != COUNT_MAX) begin
				count_n = count_q + 1'b1;
			end
			rot_origin_n = tracked_n;
		end
		if (speed < {1'b0, cfg.stall_speed}) begin
			count_n      = '0;
			rot_origin_n = tracked_n;
		end

		braking_a      = braking_q;
		brake_origin_a = brake_origin_q;
		target_a       = target_q;
		count_a        = count_n;
		if (beat_s1.deactivate) begin
			braking_a      = 1'b0;
			brake_origin_a = '0;
			target_a       = '0;
			count_a        = '0;
		end else if (beat_s1.activate && !braking_q) begin
			braking_a      = 1'b1;
			brake_origin_a = tracked_n;
			target_a       = {2'b00, speed[VEL_W-1:2]};
		end

		bdiff  = tracked_n - brake_origin_a;
		travel = bdiff[POS_W-1] ? (-bdiff) : bdiff;

		braking_n      = braking_a;
		brake_origin_n = brake_origin_a;
		target_n       = target_a;
		done           = 1'b0;
		cmd            = '0;
		if (braking_a) begin
			if ((speed <= target_a) || (travel >= QUARTER_TURN)) begin
				braking_n      = 1'b0;
				brake_origin_n = '0;
				target_n       = '0;
				count_a        = '0;
				done           = 1'b1;
			end else if (beat_s1.velocity[VEL_W-1]) begin
				cmd = $signed({1'b0, cfg.brake_duty});
			end else if (beat_s1.velocity != '0) begin
				cmd = -$signed({1'b0, cfg.brake_duty});
			end
		end

		result.angle_out       = cfg.use_measured_angle ? beat_s1.measured_angle
			: tracked_n[ANGLE_W-1:0];
		result.unwrapped_angle = $signed(tracked_n);
		result.rotations       = count_a;
		result.brake_active    = braking_n;
		result.brake_command   = cmd;
		result.brake_done      = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_meas_q    <= '0;
			seen_q         <= 1'b0;
			tracked_q      <= '0;
			rot_origin_q   <= '0;
			count_q        <= '0;
			braking_q      <= 1'b0;
			brake_origin_q <= '0;
			target_q       <= '0;
		end else if (mode_wr) begin
			seen_q <= 1'b0;
		end else if (advance) begin
			if (cfg.use_measured_angle) begin
				last_meas_q <= beat_s1.measured_angle;
				seen_q      <= 1'b1;
			end
			tracked_q      <= tracked_n;
			rot_origin_q   <= rot_origin_n;
			count_q        <= count_a;
			braking_q      <= braking_n;
			brake_origin_q <= brake_origin_n;
			target_q       <= target_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rotation_tracker_with_spin_brake.sv
// rotation_tracker_with_spin_brake: top level, stream ports, apb port and result register
// depends on rstb_pkg, rstb_cfg_regs, rstb_in_stage, rstb_track_core
//
// Takes one beat per cycle while m_tready stays high and returns one result beat per input
// beat. An accepted beat is loaded into the input register together with velocity
// times step_time, multiplied on the way in. When the result register is free or
// m_tready is high, the beat moves from the input register through the tracking and
// brake logic into the result register and is then valid on m_tvalid. The tracking state
// is updated in that single pass, so beats flow at full rate while m_tready stays high.
// Configuration is written through the apb port; writing the mode register makes the
// next measured sample set the position.
`default_nettype none

module rotation_tracker_with_spin_brake (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// measured_angle[15:0], velocity[39:16], activate[40], deactivate[41], zero pad
	input  wire logic [47:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// angle_out[15:0], unwrapped_angle[47:16], rotations[55:48], brake_active[56],
	// brake_command[65:57], brake_done[66], zero pad
	output logic [71:0]      m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import rstb_pkg::*;

	cfg_t     cfg;
	logic     mode_wr;
	logic     valid_s1;
	in_beat_t beat_s1;
	result_t  result;
	result_t  result_q;
	logic     out_valid_q;
	logic     advance;
	logic     load;

	assign pready   = 1'b1;
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	rstb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.mode_wr (mode_wr)
	);

	rstb_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.advance   (advance),
		.tdata     (s_tdata),
		.step_time (cfg.step_time),
		.valid_s1  (valid_s1),
		.beat_s1   (beat_s1)
	);

	rstb_track_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mode_wr (mode_wr),
		.cfg     (cfg),
		.beat_s1 (beat_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, result_q.brake_done, result_q.brake_command,
		result_q.brake_active, result_q.rotations, result_q.unwrapped_angle,
		result_q.angle_out};

	// a moved beat always lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	// a command is only driven while braking
	a_cmd_needs_brake: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.brake_command != '0)) |-> result_q.brake_active)
		else $error("brake command while brake idle");

	// automatic completion leaves the brake idle with the count cleared
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.brake_done) |->
		(!result_q.brake_active && (result_q.rotations == '0)))
		else $error("brake done without clearing");

endmodule

`default_nettype wire
